// ===== rtl/pwdt_pkg.sv =====
// Package for the prescaled watchdog timer: field widths, control bits, counter constants.
`default_nettype none
package pwdt_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 15;

	// Counter wraps here; the 15-bit counter holds up to this value minus one.
	localparam int COUNT_LIMIT     = 32768;
	// Tick cycle counts above this value are clamped.
	localparam int MAX_TICK_CYCLES = 255;

	// Control register bit positions
	localparam int BIT_FLAG    = 7;
	localparam int BIT_ENABLE  = 5;
	localparam int BIT_RESTART = 4;
	localparam int BIT_IDLE    = 3;
	localparam int PS_W        = 3;

	// Item kinds
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// A tick yields at most 255 prescaler periods (prescale count + cycles <= 510, shift >= 1).
	localparam int PERIOD_W = 8;
	localparam int PERIOD_N = 1 << PERIOD_W;

	typedef logic [CNT_W-1:0] period_mod_t [PERIOD_N];

	// Periods reduced modulo the counter limit, built at elaboration.
	function automatic period_mod_t build_period_mod();
		period_mod_t t;
		for (int i = 0; i < PERIOD_N; i++) begin
			t[i] = CNT_W'(i % COUNT_LIMIT);
		end
		return t;
	endfunction

	localparam period_mod_t PERIOD_MOD = build_period_mod();

endpackage
`default_nettype wire

// ===== rtl/pwdt_in_if.sv =====
// Input channel of the watchdog: tick or control write, valid/ready handshake.
`default_nettype none
interface pwdt_in_if;
	import pwdt_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [BYTE_W-1:0] write_data;
	logic [BYTE_W-1:0] tick_cycles;
	logic              cpu_idle;

	modport source (output valid, mode, write_data, tick_cycles, cpu_idle, input ready);
	modport sink   (input valid, mode, write_data, tick_cycles, cpu_idle, output ready);

endinterface
`default_nettype wire

// ===== rtl/pwdt_out_if.sv =====
// Result channel of the watchdog: control and counter snapshot, valid/ready handshake.
`default_nettype none
interface pwdt_out_if;
	import pwdt_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] control_value;
	logic [CNT_W-1:0]  count_value;
	logic              overflowed;

	modport source (output valid, control_value, count_value, overflowed, input ready);
	modport sink   (input valid, control_value, count_value, overflowed, output ready);

endinterface
`default_nettype wire

// ===== rtl/prescaled_watchdog_timer_unit.sv =====
// Prescaled watchdog timer: input register, combinational update, result register.
// Each item passes the input register and then the result register before it leaves.
// Throughput: one item per cycle while results are taken; the prescaler is resolved by shift and mask and
// the counter wrap by one table lookup, add and compare in the update stage.
// A stalled result register holds the update stage; the input register still takes one item.
// Reset (arst_n low) clears control register, prescaler, counter and both valid flags.
`default_nettype none
module prescaled_watchdog_timer_unit (
	input  wire         clk,
	input  wire         arst_n,
	pwdt_in_if.sink     cmd,
	pwdt_out_if.source  rsp
);
	import pwdt_pkg::*;

	// input stage
	logic              valid_s1;
	logic              mode_s1;
	logic [BYTE_W-1:0] wdata_s1;
	logic [BYTE_W-1:0] cycles_s1;
	logic              idle_s1;

	// state
	logic [BYTE_W-1:0] ctrl_q;
	logic [BYTE_W-1:0] presc_q;
	logic [CNT_W-1:0]  watch_q;

	// result stage
	logic              valid_s2;
	logic [BYTE_W-1:0] ctrl_s2;
	logic [CNT_W-1:0]  count_s2;
	logic              ovf_s2;

	logic advance;
	logic update;

	assign advance   = !valid_s2 || rsp.ready;
	assign update    = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	// next-state logic
	logic [PS_W-1:0]     ps;
	logic [BYTE_W-1:0]   cyc;
	logic [BYTE_W:0]     total;
	logic [BYTE_W:0]     mask;
	logic [PERIOD_W-1:0] periods;
	logic [CNT_W-1:0]    per_red;
	logic [CNT_W:0]      sum;
	logic                wrap;
	logic                count_en;

	logic [BYTE_W-1:0] ctrl_n;
	logic [BYTE_W-1:0] presc_n;
	logic [CNT_W-1:0]  watch_n;
	logic              ovf_n;

	always_comb begin
		ps       = ctrl_q[PS_W-1:0];
		cyc      = (32'(cycles_s1) > MAX_TICK_CYCLES) ? BYTE_W'(MAX_TICK_CYCLES) : cycles_s1;
		total    = {1'b0, presc_q} + {1'b0, cyc};
		mask     = ((BYTE_W+1)'(2) << ps) - (BYTE_W+1)'(1);
		periods  = PERIOD_W'(total >> ({1'b0, ps} + 4'd1));
		per_red  = PERIOD_MOD[periods];
		sum      = {1'b0, watch_q} + {1'b0, per_red};
		// a wrap happened if the raw period count alone reached the limit too
		wrap     = (32'(periods) >= COUNT_LIMIT) || (32'(sum) >= COUNT_LIMIT);
		count_en = ctrl_q[BIT_ENABLE] && (!idle_s1 || ctrl_q[BIT_IDLE]);

		ctrl_n  = ctrl_q;
		presc_n = presc_q;
		watch_n = watch_q;
		ovf_n   = 1'b0;

		unique case (mode_s1)
			MODE_WRITE: begin
				ctrl_n              = wdata_s1;
				ctrl_n[BIT_RESTART] = 1'b0;
				if (wdata_s1[BIT_RESTART]) begin
					presc_n = '0;
					watch_n = '0;
				end
			end
			MODE_TICK: begin
				if (count_en) begin
					presc_n = BYTE_W'(total & mask);
					if (32'(sum) >= COUNT_LIMIT) begin
						watch_n = CNT_W'(sum - (CNT_W+1)'(COUNT_LIMIT));
					end else begin
						watch_n = CNT_W'(sum);
					end
					if (wrap) begin
						ctrl_n[BIT_FLAG] = 1'b1;
						ovf_n            = 1'b1;
					end
				end
			end
			default: begin
				ctrl_n = ctrl_q;
			end
		endcase
	end

	// control flags and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctrl_q   <= '0;
			presc_q  <= '0;
			watch_q  <= '0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (update) begin
				valid_s2 <= 1'b1;
				ctrl_q   <= ctrl_n;
				presc_q  <= presc_n;
				watch_q  <= watch_n;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1   <= cmd.mode;
			wdata_s1  <= cmd.write_data;
			cycles_s1 <= cmd.tick_cycles;
			idle_s1   <= cmd.cpu_idle;
		end
		if (update) begin
			ctrl_s2  <= ctrl_n;
			count_s2 <= watch_n;
			ovf_s2   <= ovf_n;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.control_value = ctrl_s2;
	assign rsp.count_value   = count_s2;
	assign rsp.overflowed    = ovf_s2;

endmodule
`default_nettype wire

// ===== rtl/pwdt_checker.sv =====
// Port-level checks for the prescaled watchdog timer, bound to the top level.
`default_nettype none
module pwdt_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire [pwdt_pkg::BYTE_W-1:0] control_value,
	input wire [pwdt_pkg::CNT_W-1:0]  count_value,
	input wire                        overflowed
);
	import pwdt_pkg::*;

	// restart bit is never stored
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !control_value[BIT_RESTART])
		else $error("restart bit visible in control value");

	// a wrap always leaves the flag set
	a_wrap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && overflowed) |-> control_value[BIT_FLAG])
		else $error("overflow without flag");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(count_value) < COUNT_LIMIT))
		else $error("counter beyond limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(control_value) && $stable(count_value) && $stable(overflowed)))
		else $error("stalled result changed");

endmodule

bind prescaled_watchdog_timer_unit pwdt_checker u_pwdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.control_value (rsp.control_value),
	.count_value   (rsp.count_value),
	.overflowed    (rsp.overflowed)
);
`default_nettype wire
